// ----- design/gprc_pkg.sv -----
// Package for the grouped presence ratio counter.
// Value class codes, fixed-point scale and the divider result bundle.
// No dependencies.
package gprc_pkg;

  // value class codes
  localparam logic [1:0] CLASS_ABSENT  = 2'd0;
  localparam logic [1:0] CLASS_PRESENT = 2'd1;

  // percent with 8 fraction bits
  localparam int          PCT_BITS  = 15;
  localparam logic [14:0] PCT_SCALE = 15'd25600;

  typedef struct packed {
    logic                done;
    logic [PCT_BITS-1:0] quot;
  } div_res_t;

endpackage

// ----- design/gprc_ifs.sv -----
// Stream interfaces for the grouped presence ratio counter.
// Item channel and result channel, valid/ready. Depends on nothing.
interface gprc_in_if;
  logic       valid;
  logic       ready;
  logic       clear_all;
  logic [7:0] column_index;
  logic [3:0] group_index;
  logic [1:0] value_class;

  modport source (output valid, clear_all, column_index, group_index, value_class,
                  input ready);
  modport sink   (input valid, clear_all, column_index, group_index, value_class,
                  output ready);
endinterface

interface gprc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] constancy_pct;
  logic        constancy_valid;
  logic [14:0] fidelity_pct;
  logic        fidelity_valid;

  modport source (output valid, constancy_pct, constancy_valid, fidelity_pct,
                  fidelity_valid, input ready);
  modport sink   (input valid, constancy_pct, constancy_valid, fidelity_pct,
                  fidelity_valid, output ready);
endinterface

// ----- design/gprc_count_store.sv -----
// Count store: cell memory (presence, absence) and column total memory.
// Registered reads, one write port each, clearing sweep.
// Depends on nothing.
module gprc_count_store #(
  parameter int CELLS   = 4096,
  parameter int COLUMNS = 256,
  parameter int CB      = 16,
  parameter int CELL_AW = 12,
  parameter int COL_AW  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear_start,
  output logic              clear_busy,
  input  logic              rd_en,
  input  logic [CELL_AW-1:0] rd_cell,
  input  logic [COL_AW-1:0]  rd_col,
  output logic [2*CB-1:0]   cell_q,
  output logic [CB-1:0]     total_q,
  input  logic              wr_en,
  input  logic [CELL_AW-1:0] wr_cell,
  input  logic [COL_AW-1:0]  wr_col,
  input  logic [2*CB-1:0]   wr_cell_d,
  input  logic [CB-1:0]     wr_total_d
);

  logic [2*CB-1:0] cell_mem [CELLS];
  logic [CB-1:0]   total_mem [COLUMNS];

  logic [CELL_AW-1:0] sweep;
  logic               busy;

  logic               cw_en;
  logic [CELL_AW-1:0] cw_addr;
  logic [2*CB-1:0]    cw_d;
  logic               tw_en;
  logic [COL_AW-1:0]  tw_addr;
  logic [CB-1:0]      tw_d;

  assign clear_busy = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      if (sweep == CELL_AW'(CELLS - 1)) begin
        busy  <= 1'b0;
        sweep <= '0;
      end else begin
        sweep <= sweep + 1'b1;
      end
    end else if (clear_start) begin
      busy  <= 1'b1;
      sweep <= '0;
    end
  end

  // sweep owns the write ports while clearing
  always_comb begin
    if (busy) begin
      cw_en   = 1'b1;
      cw_addr = sweep;
      cw_d    = '0;
      tw_en   = (32'(sweep) < COLUMNS);
      tw_addr = COL_AW'(sweep);
      tw_d    = '0;
    end else begin
      cw_en   = wr_en;
      cw_addr = wr_cell;
      cw_d    = wr_cell_d;
      tw_en   = wr_en;
      tw_addr = wr_col;
      tw_d    = wr_total_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cell_mem[cw_addr] <= cw_d;
    end
    if (rd_en) begin
      cell_q <= cell_mem[rd_cell];
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      total_mem[tw_addr] <= tw_d;
    end
    if (rd_en) begin
      total_q <= total_mem[rd_col];
    end
  end

endmodule

// ----- design/gprc_divider.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Gives floor(num/den) clamped to the percent scale. Uses gprc_pkg.
module gprc_divider #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output gprc_pkg::div_res_t res
);

  localparam int QB = gprc_pkg::PCT_BITS;
  localparam int RW = DEN_W + 1;
  localparam int CW = $clog2(QB);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [QB-1:0]    num_lo;
  logic [QB-1:0]    quot;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic             ovf;
  logic [RW-1:0]    trial;
  logic             fits;

  assign trial = {rem, num_lo[QB-1]};
  assign fits  = (trial >= RW'(den_r));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CW'(QB - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CW'(QB - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient that needs more than QB bits is clamped below
      ovf    <= (RW'(num[NUM_W-1:QB]) >= RW'(den));
      rem    <= DEN_W'(num[NUM_W-1:QB]);
      num_lo <= num[QB-1:0];
      den_r  <= den;
      quot   <= '0;
      cnt    <= '0;
    end else if (busy) begin
      rem    <= fits ? DEN_W'(trial - RW'(den_r)) : DEN_W'(trial);
      quot   <= {quot[QB-2:0], fits};
      num_lo <= {num_lo[QB-2:0], 1'b0};
      cnt    <= cnt + 1'b1;
    end
  end

  always_comb begin
    res.done = done;
    if (ovf || (quot > gprc_pkg::PCT_SCALE)) begin
      res.quot = gprc_pkg::PCT_SCALE;
    end else begin
      res.quot = quot;
    end
  end

endmodule

// ----- design/grouped_presence_ratio_counter.sv -----
// Grouped presence ratio counter, top level.
// Uses gprc_pkg, gprc_ifs, gprc_count_store and gprc_divider.
//
// Usage:
//   item   (sink):   one table cell per beat: clear_all, column_index,
//                    group_index, value_class (0 absent, 1 present,
//                    2/3 query only).
//   result (source): one beat per item: constancy_pct and fidelity_pct,
//                    percent with 8 fraction bits, truncated, each with a
//                    valid flag that is low when its divisor is zero.
// Counts per (column, group) live in one memory word {presence, absence};
// column presence totals in a second memory. Counters saturate.
// Timing: an item is read from the store, updated and written back, then
// the shared divider runs twice (constancy, then fidelity), 15 steps each,
// one quotient bit per cycle, with a done flag after each division.
// The result register loads from the final state; items go through one at
// a time, so the next item is taken only after that load.
// An out-of-range column or group skips the update and divisions and goes
// from the store read straight to the result load.
// Reset and clear_all both start a clearing sweep over all COLUMNS*GROUPS
// cells (4096 by default) and the column totals, during which no item is taken;
// with clear_all the item itself is processed after the sweep.
// Result sits in an output register: the next item is accepted while a
// result waits. A stalled receiver only holds the block before its final
// load of the output register.
module grouped_presence_ratio_counter #(
  parameter int COLUMNS    = 256,
  parameter int GROUPS     = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  gprc_in_if.sink     item,
  gprc_out_if.source  result
);

  localparam int CELLS   = COLUMNS * GROUPS;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_AW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CB      = COUNT_BITS;
  localparam int DEN_W   = CB + 1;
  localparam int QB      = gprc_pkg::PCT_BITS;
  localparam int NUM_W   = CB + QB;
  localparam logic [CB-1:0] CNT_MAX = '1;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_READ   = 10'b0000000100,
    S_MOD    = 10'b0000001000,
    S_MUL    = 10'b0000010000,
    S_START1 = 10'b0000100000,
    S_WAIT1  = 10'b0001000000,
    S_START2 = 10'b0010000000,
    S_WAIT2  = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // latched item
  logic               pend;
  logic               in_range;
  logic [1:0]         cls;
  logic [CELL_AW-1:0] cell_addr;
  logic [COL_AW-1:0]  col_addr;

  // working values
  logic [CB-1:0]      p_r;
  logic [DEN_W-1:0]   sum_r;
  logic [CB-1:0]      t_r;
  logic [NUM_W-1:0]   num_r;
  logic               cval;
  logic               fval;
  logic [QB-1:0]      q1;
  logic [QB-1:0]      q2;

  // store ports
  logic               clear_start;
  logic               clear_busy;
  logic [2*CB-1:0]    cell_q;
  logic [CB-1:0]      total_q;
  logic [CB-1:0]      p_cur, a_cur;
  logic [CB-1:0]      p_new, a_new, t_new;

  // divider ports
  logic                div_start;
  logic [DEN_W-1:0]    div_den;
  gprc_pkg::div_res_t  div_res;

  logic accept;
  logic out_free;

  assign accept    = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign out_free  = !result.valid || result.ready;

  assign clear_start = accept && item.clear_all;

  gprc_count_store #(
    .CELLS   (CELLS),
    .COLUMNS (COLUMNS),
    .CB      (CB),
    .CELL_AW (CELL_AW),
    .COL_AW  (COL_AW)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .clear_start (clear_start),
    .clear_busy  (clear_busy),
    .rd_en       (state == S_READ),
    .rd_cell     (cell_addr),
    .rd_col      (col_addr),
    .cell_q      (cell_q),
    .total_q     (total_q),
    .wr_en       (state == S_MOD),
    .wr_cell     (cell_addr),
    .wr_col      (col_addr),
    .wr_cell_d   ({p_new, a_new}),
    .wr_total_d  (t_new)
  );

  // saturating read-modify-write of the three counters
  assign p_cur = cell_q[2*CB-1:CB];
  assign a_cur = cell_q[CB-1:0];
  assign p_new = ((cls == gprc_pkg::CLASS_PRESENT) && (p_cur != CNT_MAX)) ?
                 p_cur + 1'b1 : p_cur;
  assign a_new = ((cls == gprc_pkg::CLASS_ABSENT) && (a_cur != CNT_MAX)) ?
                 a_cur + 1'b1 : a_cur;
  assign t_new = ((cls == gprc_pkg::CLASS_PRESENT) && (total_q != CNT_MAX)) ?
                 total_q + 1'b1 : total_q;

  assign div_start = (state == S_START1) || (state == S_START2);
  assign div_den   = (state == S_START1) ? sum_r : DEN_W'(t_r);

  gprc_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_r),
    .den   (div_den),
    .res   (div_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (!clear_busy) state_next = pend ? S_READ : S_IDLE;
      S_IDLE:   if (accept) state_next = item.clear_all ? S_CLEAR : S_READ;
      S_READ:   state_next = in_range ? S_MOD : S_FIN;
      S_MOD:    state_next = S_MUL;
      S_MUL:    state_next = S_START1;
      S_START1: state_next = S_WAIT1;
      S_WAIT1:  if (div_res.done) state_next = S_START2;
      S_START2: state_next = S_WAIT2;
      S_WAIT2:  if (div_res.done) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pend <= item.clear_all;
      end else if ((state == S_CLEAR) && !clear_busy) begin
        pend <= 1'b0;
      end
    end
  end

  // item latch and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_range  <= (32'(item.column_index) < COLUMNS) &&
                   (32'(item.group_index) < GROUPS);
      cls       <= item.value_class;
      cell_addr <= CELL_AW'(32'(item.column_index) * GROUPS + 32'(item.group_index));
      col_addr  <= COL_AW'(item.column_index);
    end
    if ((state == S_READ) && !in_range) begin
      cval <= 1'b0;
      fval <= 1'b0;
    end
    if (state == S_MOD) begin
      p_r   <= p_new;
      sum_r <= DEN_W'(p_new) + DEN_W'(a_new);
      t_r   <= t_new;
      cval  <= (p_new != '0) || (a_new != '0);
      fval  <= (t_new != '0);
    end
    if (state == S_MUL) begin
      num_r <= NUM_W'(p_r) * NUM_W'(gprc_pkg::PCT_SCALE);
    end
    if ((state == S_WAIT1) && div_res.done) begin
      q1 <= div_res.quot;
    end
    if ((state == S_WAIT2) && div_res.done) begin
      q2 <= div_res.quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      result.constancy_pct   <= cval ? q1 : '0;
      result.constancy_valid <= cval;
      result.fidelity_pct    <= fval ? q2 : '0;
      result.fidelity_valid  <= fval;
    end
  end

endmodule

// ----- dv/grouped_presence_ratio_counter_tb.sv -----
// Self-checking testbench for grouped_presence_ratio_counter.
// Needs gprc_pkg, gprc_ifs and the RTL under design/. Runs a directed table,
// then random cells, and checks every result beat against the predictor or a fixed table value.
module grouped_presence_ratio_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PCT_BITS      = gprc_pkg::PCT_BITS;
  localparam logic [14:0] PCT_SCALE     = gprc_pkg::PCT_SCALE;
  localparam logic [1:0]  CLASS_ABSENT  = gprc_pkg::CLASS_ABSENT;
  localparam logic [1:0]  CLASS_PRESENT = gprc_pkg::CLASS_PRESENT;

  localparam int COLUMNS    = 256;
  localparam int GROUPS     = 16;
  localparam int COUNT_BITS = 16;
  localparam int CELLS      = COLUMNS * GROUPS;

  // Value classes 2 and 3 only query; the package names just the counted ones.
  localparam logic [1:0] CLASS_QUERY     = 2'd2;
  localparam logic [1:0] CLASS_QUERY_ALT = 2'd3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int RANDOM_CELLS = 1150;
  // Cycles with no beat on either side before the run is declared hung.
  // It must outlast a clear sweep, the item latency and the longest gap
  // and stall, with plenty of margin.
  localparam int HANG_LIMIT  = 4 * CELLS + 2000;
  localparam int DRAIN_WAIT  = 64;
  localparam int SHOW_ERRORS = 10;

  typedef struct packed {
    logic       clear_all;
    logic [7:0] column_index;
    logic [3:0] group_index;
    logic [1:0] value_class;
  } cell_item_t;

  typedef struct packed {
    logic [PCT_BITS-1:0] constancy_pct;
    logic                constancy_valid;
    logic [PCT_BITS-1:0] fidelity_pct;
    logic                fidelity_valid;
  } ratio_pair_t;

  // One row of the directed table. Where fixed is set, want is the
  // expected result read straight off the ratios; otherwise the
  // predictor supplies it.
  typedef struct packed {
    cell_item_t  stim;
    logic        fixed;
    ratio_pair_t want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 19;

  // Rows build up col 0 / col 255, cross a clear, then hit alternating
  // bit patterns on column and group.
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // fresh from reset: a query sees nothing, both ratios invalid
    '{'{1'b0, 8'd0,   4'd0,  CLASS_QUERY},     1'b1, '{15'd0,     1'b0, 15'd0,     1'b0}},
    '{'{1'b0, 8'd0,   4'd0,  CLASS_PRESENT},   1'b1, '{15'd25600, 1'b1, 15'd25600, 1'b1}},
    '{'{1'b0, 8'd0,   4'd0,  CLASS_ABSENT},    1'b1, '{15'd12800, 1'b1, 15'd25600, 1'b1}},
    '{'{1'b0, 8'd0,   4'd1,  CLASS_PRESENT},   1'b1, '{15'd25600, 1'b1, 15'd12800, 1'b1}},
    '{'{1'b0, 8'd0,   4'd1,  CLASS_QUERY_ALT}, 1'b1, '{15'd25600, 1'b1, 15'd12800, 1'b1}},
    // top column / top group: absences only, column total still zero
    '{'{1'b0, 8'd255, 4'd15, CLASS_ABSENT},    1'b1, '{15'd0,     1'b1, 15'd0,     1'b0}},
    '{'{1'b0, 8'd255, 4'd15, CLASS_QUERY_ALT}, 1'b1, '{15'd0,     1'b1, 15'd0,     1'b0}},
    '{'{1'b0, 8'd255, 4'd15, CLASS_PRESENT},   1'b1, '{15'd12800, 1'b1, 15'd25600, 1'b1}},
    // empty cell in a column that has presences: fidelity valid and zero
    '{'{1'b0, 8'd255, 4'd0,  CLASS_QUERY},     1'b1, '{15'd0,     1'b0, 15'd0,     1'b1}},
    '{'{1'b0, 8'd0,   4'd0,  CLASS_ABSENT},    1'b0, '0},
    '{'{1'b0, 8'd0,   4'd0,  CLASS_ABSENT},    1'b1, '{15'd6400,  1'b1, 15'd12800, 1'b1}},
    // clear lands before the cell is counted
    '{'{1'b1, 8'd128, 4'd7,  CLASS_PRESENT},   1'b1, '{15'd25600, 1'b1, 15'd25600, 1'b1}},
    '{'{1'b0, 8'd0,   4'd0,  CLASS_QUERY},     1'b1, '{15'd0,     1'b0, 15'd0,     1'b0}},
    '{'{1'b0, 8'd255, 4'd15, CLASS_QUERY},     1'b1, '{15'd0,     1'b0, 15'd0,     1'b0}},
    '{'{1'b0, 8'd170, 4'd10, CLASS_PRESENT},   1'b0, '0},
    '{'{1'b0, 8'd85,  4'd5,  CLASS_ABSENT},    1'b0, '0},
    '{'{1'b0, 8'd85,  4'd5,  CLASS_PRESENT},   1'b0, '0},
    '{'{1'b0, 8'd170, 4'd5,  CLASS_PRESENT},   1'b0, '0},
    '{'{1'b1, 8'd3,   4'd3,  CLASS_ABSENT},    1'b1, '{15'd0,     1'b1, 15'd0,     1'b0}}
  };

  logic clk = 1'b0;
  logic rst;

  gprc_in_if  item_bus ();
  gprc_out_if result_bus ();

  grouped_presence_ratio_counter #(
    .COLUMNS   (COLUMNS),
    .GROUPS    (GROUPS),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_bus),
    .result(result_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: per-cell presence/absence counts and per-column
  // presence totals, all saturating at COUNT_BITS.
  // ---------------------------------------------------------------------
  logic [COUNT_BITS-1:0] present_cnt   [CELLS];
  logic [COUNT_BITS-1:0] absent_cnt    [CELLS];
  logic [COUNT_BITS-1:0] col_pres_total[COLUMNS];

  ratio_pair_t pending_ratios[$];   // predicted result beats, oldest first

  int  mismatches  = 0;
  int  quiet_cycles = 0;
  bit  gaps_on     = 1'b1;          // off for stretches of back-to-back beats
  logic [7:0] hot_cols[4];          // columns most random cells land in

  function automatic void wipe_counts();
    foreach (present_cnt[i]) begin
      present_cnt[i] = '0;
      absent_cnt[i]  = '0;
    end
    foreach (col_pres_total[i]) col_pres_total[i] = '0;
  endfunction

  // floor(25600 * num / den), clamped to full scale; zero when den is zero
  function automatic logic [PCT_BITS-1:0] q8_percent(input longint unsigned num,
                                                     input longint unsigned den);
    longint unsigned q;
    if (den == 0) return '0;
    q = (num * longint'(PCT_SCALE)) / den;
    if (q > longint'(PCT_SCALE)) q = longint'(PCT_SCALE);
    return q[PCT_BITS-1:0];
  endfunction

  // Apply one accepted cell to the counts and return the ratios it yields.
  function automatic ratio_pair_t tally_cell(input cell_item_t c);
    ratio_pair_t r;
    int cidx;
    longint unsigned p, a, t;
    r = '0;
    if (c.clear_all) wipe_counts();
    // out-of-range index: nothing counted, all-zero result
    if (c.column_index >= COLUMNS || c.group_index >= GROUPS) return r;
    cidx = int'(c.column_index) * GROUPS + int'(c.group_index);
    if (c.value_class == CLASS_PRESENT) begin
      if (present_cnt[cidx] != COUNT_MAX) present_cnt[cidx] = present_cnt[cidx] + 1'b1;
      if (col_pres_total[c.column_index] != COUNT_MAX)
        col_pres_total[c.column_index] = col_pres_total[c.column_index] + 1'b1;
    end else if (c.value_class == CLASS_ABSENT) begin
      if (absent_cnt[cidx] != COUNT_MAX) absent_cnt[cidx] = absent_cnt[cidx] + 1'b1;
    end
    // classes 2 and 3 fall through as pure queries
    p = present_cnt[cidx];
    a = absent_cnt[cidx];
    t = col_pres_total[c.column_index];
    if (p + a != 0) begin
      r.constancy_pct   = q8_percent(p, p + a);
      r.constancy_valid = 1'b1;
    end
    if (t != 0) begin
      r.fidelity_pct   = q8_percent(p, t);
      r.fidelity_valid = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly short gaps, a few long ones; none while gaps_on is clear.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void pick_hot_cols();
    foreach (hot_cols[i]) hot_cols[i] = 8'($urandom_range(255));
  endfunction

  // Most cells fall on a few hot columns so per-cell counts grow and the
  // ratios take many values; the rest spread over the whole table. A rare
  // clear starts a new table with new hot columns.
  function automatic cell_item_t random_cell();
    cell_item_t c;
    int unsigned r;
    c.clear_all = ($urandom_range(149) == 0);
    if (c.clear_all) pick_hot_cols();
    c.column_index = ($urandom_range(99) < 80) ? hot_cols[$urandom_range(3)]
                                               : 8'($urandom_range(255));
    c.group_index = 4'($urandom_range(15));
    r = $urandom_range(99);
    if (r < 45)      c.value_class = CLASS_PRESENT;
    else if (r < 80) c.value_class = CLASS_ABSENT;
    else if (r < 94) c.value_class = CLASS_QUERY;
    else             c.value_class = CLASS_QUERY_ALT;
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  // valid is lowered only when a gap follows, so it never toggles twice
  // in one step.
  task automatic send_cell(input cell_item_t c, input bit fixed, input ratio_pair_t want);
    int gap;
    ratio_pair_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      item_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.valid        = 1'b1;
    item_bus.clear_all    = c.clear_all;
    item_bus.column_index = c.column_index;
    item_bus.group_index  = c.group_index;
    item_bus.value_class  = c.value_class;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    predicted = tally_cell(c);
    pending_ratios.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, driven on the falling edge
  // ---------------------------------------------------------------------
  initial begin
    int stall_left;
    int unsigned r;
    stall_left = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst || !gaps_on) begin
        stall_left = 0;
        result_bus.ready = !rst;
      end else if (stall_left > 0) begin
        stall_left--;
        result_bus.ready = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 70)      stall_left = 0;
        else if (r < 93) stall_left = $urandom_range(3, 1);
        else if (r < 98) stall_left = $urandom_range(12, 4);
        else             stall_left = $urandom_range(80, 20);
        result_bus.ready = (stall_left == 0);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: every result beat against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    ratio_pair_t exp_r;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_ratios.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_ERRORS)
          $display("[%0t] result beat with no item outstanding", $realtime);
      end else begin
        exp_r = pending_ratios.pop_front();
        if (result_bus.constancy_pct   !== exp_r.constancy_pct   ||
            result_bus.constancy_valid !== exp_r.constancy_valid ||
            result_bus.fidelity_pct    !== exp_r.fidelity_pct    ||
            result_bus.fidelity_valid  !== exp_r.fidelity_valid) begin
          mismatches++;
          if (mismatches <= SHOW_ERRORS)
            $display({"[%0t] ratio mismatch: exp const %0d/%0b fid %0d/%0b,",
                      " got const %0d/%0b fid %0d/%0b"},
                     $realtime, exp_r.constancy_pct, exp_r.constancy_valid,
                     exp_r.fidelity_pct, exp_r.fidelity_valid,
                     result_bus.constancy_pct, result_bus.constancy_valid,
                     result_bus.fidelity_pct, result_bus.fidelity_valid);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Hang watchdog: cycles with no beat on either channel
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= HANG_LIMIT);
    $display("grouped_presence_ratio_counter regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    item_bus.valid        = 1'b0;
    item_bus.clear_all    = 1'b0;
    item_bus.column_index = '0;
    item_bus.group_index  = '0;
    item_bus.value_class  = CLASS_ABSENT;
    wipe_counts();
    pick_hot_cols();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. The first beat also waits out the post-reset
    // clearing sweep, which the handshake covers.
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_cell(DIRECTED[i].stim, DIRECTED[i].fixed, DIRECTED[i].want);

    // Random cells, in blocks that switch idling on and off so some
    // stretches run back to back on both sides.
    for (int n = 0; n < RANDOM_CELLS; n++) begin
      if (n % 100 == 0) gaps_on = ($urandom_range(3) != 0);
      send_cell(random_cell(), 1'b0, '0);
    end
    item_bus.valid = 1'b0;

    // Drain, then give a stray beat time to show up.
    while (pending_ratios.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0)
      $display("grouped_presence_ratio_counter regression: pass");
    else
      $display("grouped_presence_ratio_counter regression: fail");
    $finish;
  end

endmodule
